[rtl/pps_pkg.sv]
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants of the preemptive priority scheduler
// Holds the request and result payloads, the ready table entry and the
// sequencer and status codes.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_TASKS_DEF   = 16;

    localparam logic REQ_ADMIT = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    typedef enum logic [1:0] {
        ST_ADMITTED = 2'd0,
        ST_REJECTED = 2'd1,
        ST_IDLE     = 2'd2,
        ST_RAN      = 2'd3
    } t_status;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  task_id;
        logic [15:0] burst_len;
        logic [7:0]  task_priority;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [7:0]  running_id;
        logic        finished;
        logic [31:0] finish_time;
        logic [31:0] turnaround;
        logic [31:0] waiting;
    } t_res;

    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  prio;
        logic [15:0] rem;
        logic [15:0] burst;
        logic [31:0] arrival;
        logic [31:0] seq;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef struct packed {
        logic clear;
        logic sample;
    } t_pick_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_APPLY,
        S_FIN1,
        S_FIN2,
        S_OUT
    } t_state;

endpackage

[rtl/pps_stream_if.sv]
// ----------------------------------------------------------------------------
// pps_stream_if: valid/ready channel
// Carries one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface pps_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/pps_ram.sv]
// ----------------------------------------------------------------------------
// pps_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/pps_pick.sv]
// ----------------------------------------------------------------------------
// pps_pick: best-candidate tracker
// Compares one ready-table entry per cycle against the best so far: lower
// priority value wins, then the larger age.
// ----------------------------------------------------------------------------
module pps_pick #(
    parameter int QUEUE_DEPTH = pps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pps_pkg::t_pick_ctl             i_ctl,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_idx,
    input  pps_pkg::t_slot                 i_slot,
    input  logic [31:0]                    i_icnt,
    output logic                           o_found,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_idx,
    output pps_pkg::t_slot                 o_best
);
    import pps_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    logic             r_found;
    logic [IDX_W-1:0] r_idx;
    t_slot            r_best;
    logic [31:0]      r_best_age;
    logic [31:0]      age;
    logic             better;

    always_comb begin
        age    = i_icnt - i_slot.seq;
        better = !r_found || (i_slot.prio < r_best.prio) ||
                 ((i_slot.prio == r_best.prio) && (age > r_best_age));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (i_ctl.sample && better) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_ctl.clear && i_ctl.sample && better) begin
            r_best     <= i_slot;
            r_best_age <= age;
            r_idx      <= i_idx;
        end
    end

    assign o_found = r_found;
    assign o_idx   = r_idx;
    assign o_best  = r_best;
endmodule

[rtl/preemptive_priority_scheduler.sv]
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler: unit-slice preemptive priority scheduler
// Admits tasks into a ready table and, on each tick, selects and runs the
// most urgent task, preempting the running one when strictly more urgent.
//
//   channel  dir  payload  transfer when
//   i_req    in   t_req    i_req.valid && i_req.ready
//   o_res    out  t_res    o_res.valid && o_res.ready
//
// An item steps from IDLE through SCAN over every table entry, DRAIN,
// APPLY and OUT, with FIN1 and FIN2 after APPLY on a tick that completes a task.
// The walk over the ready table, one entry per cycle through the single
// read port of the table RAM into the shared compare unit, sets the pace.
// Reset clears the control state; valid bits mark table entries.
// A result waits in the output register while the next item is taken; the
// final step of that item holds until the earlier result is transferred.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
    parameter int QUEUE_DEPTH = pps_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_TASKS   = pps_pkg::MAX_TASKS_DEF
) (
    input logic          i_clk,
    input logic          i_rst_n,
    pps_stream_if.sink   i_req,
    pps_stream_if.source o_res
);
    import pps_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int MT_W  = $clog2(MAX_TASKS + 1);
    localparam int TOT_W = ((MT_W > CNT_W) ? MT_W : CNT_W) + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    t_state                 r_state, n_state;
    t_req                   r_req;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_pipe_vld;
    logic [IDX_W-1:0]       r_pipe_idx;
    logic                   r_free_found;
    logic [IDX_W-1:0]       r_free_idx;
    logic [QUEUE_DEPTH-1:0] r_slot_valid;
    logic [CNT_W-1:0]       r_count;
    logic [31:0]            r_icnt;
    logic [31:0]            r_time;
    logic                   r_run_valid;
    logic [7:0]             r_run_id;
    logic [7:0]             r_run_prio;
    logic [15:0]            r_run_rem;
    logic [15:0]            r_run_burst;
    logic [31:0]            r_run_arrival;
    t_res                   r_res;
    logic                   r_o_vld;
    t_res                   r_o_data;

    logic                   req_xfer;
    logic                   out_load;
    t_pick_ctl              pick_ctl;
    logic [IDX_W-1:0]       ram_raddr;
    logic [SLOT_W-1:0]      ram_rdata;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    t_slot                  ram_wdata;
    logic                   best_found;
    logic [IDX_W-1:0]       best_idx;
    t_slot                  best;

    logic                   is_tick;
    logic                   admit_ok;
    logic                   tick_idle;
    logic                   take;
    logic [7:0]             sel_id;
    logic [7:0]             sel_prio;
    logic [15:0]            sel_rem;
    logic [15:0]            sel_burst;
    logic [31:0]            sel_arrival;
    logic [15:0]            sel_rem_dec;
    logic                   sel_fin;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (req_xfer) n_state = S_SCAN;
            S_SCAN:  if (r_idx == LAST_IDX) n_state = S_DRAIN;
            S_DRAIN: n_state = S_APPLY;
            S_APPLY: n_state = (is_tick && !tick_idle && sel_fin) ? S_FIN1 : S_OUT;
            S_FIN1:  n_state = S_FIN2;
            S_FIN2:  n_state = S_OUT;
            S_OUT:   if (!r_o_vld || o_res.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        i_req.ready     = 1'b0;
        pick_ctl.clear  = 1'b0;
        pick_ctl.sample = 1'b0;
        ram_raddr       = r_idx;
        out_load        = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_req.ready    = 1'b1;
                pick_ctl.clear = 1'b1;
            end
            S_SCAN, S_DRAIN: begin
                pick_ctl.sample = r_pipe_vld;
            end
            S_OUT: begin
                out_load = !r_o_vld || o_res.ready;
            end
            default: begin
                pick_ctl.sample = 1'b0;
            end
        endcase
    end

    assign req_xfer = i_req.valid && (r_state == S_IDLE);
    assign is_tick  = (r_req.req_type == REQ_TICK);

    always_comb begin
        admit_ok = (r_req.burst_len != 16'd0) && (r_req.task_id != 8'd0) && r_free_found &&
                   ((TOT_W'(r_count) + TOT_W'(r_run_valid)) < TOT_W'(MAX_TASKS));
        tick_idle = !best_found && !r_run_valid;
        take      = best_found && (!r_run_valid || (best.prio < r_run_prio));
        sel_id      = take ? best.id      : r_run_id;
        sel_prio    = take ? best.prio    : r_run_prio;
        sel_rem     = take ? best.rem     : r_run_rem;
        sel_burst   = take ? best.burst   : r_run_burst;
        sel_arrival = take ? best.arrival : r_run_arrival;
        sel_rem_dec = (sel_rem != 16'd0) ? (sel_rem - 16'd1) : 16'd0;
        sel_fin     = (sel_rem_dec == 16'd0);
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_free_idx;
        ram_wdata = '{id: r_req.task_id, prio: r_req.task_priority, rem: r_req.burst_len,
                      burst: r_req.burst_len, arrival: r_time, seq: r_icnt};
        if (r_state == S_APPLY) begin
            if (!is_tick) begin
                ram_we = admit_ok;
            end else begin
                ram_we    = take && r_run_valid;
                ram_waddr = best_idx;
                ram_wdata = '{id: r_run_id, prio: r_run_prio, rem: r_run_rem,
                              burst: r_run_burst, arrival: r_run_arrival, seq: r_icnt};
            end
        end
    end

    pps_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pps_pick #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_pick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (pick_ctl),
        .i_idx   (r_pipe_idx),
        .i_slot  (t_slot'(ram_rdata)),
        .i_icnt  (r_icnt),
        .o_found (best_found),
        .o_idx   (best_idx),
        .o_best  (best)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_idx         <= '0;
            r_pipe_vld    <= 1'b0;
            r_free_found  <= 1'b0;
            r_slot_valid  <= '0;
            r_count       <= '0;
            r_icnt        <= '0;
            r_time        <= '0;
            r_run_valid   <= 1'b0;
            r_run_id      <= '0;
            r_run_prio    <= '0;
            r_run_rem     <= '0;
            r_run_burst   <= '0;
            r_run_arrival <= '0;
            r_o_vld       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_o_vld <= out_load || (r_o_vld && !o_res.ready);
            case (r_state)
                S_IDLE: begin
                    r_idx        <= '0;
                    r_pipe_vld   <= 1'b0;
                    r_free_found <= 1'b0;
                end
                S_SCAN: begin
                    r_pipe_vld <= r_slot_valid[r_idx] && is_tick;
                    if (!r_slot_valid[r_idx] && !r_free_found) begin
                        r_free_found <= 1'b1;
                    end
                    r_idx <= r_idx + IDX_W'(1);
                end
                S_DRAIN: begin
                    r_pipe_vld <= 1'b0;
                end
                S_APPLY: begin
                    if (!is_tick) begin
                        if (admit_ok) begin
                            r_slot_valid[r_free_idx] <= 1'b1;
                            r_count                  <= r_count + CNT_W'(1);
                            r_icnt                   <= r_icnt + 32'd1;
                        end
                    end else begin
                        r_time <= r_time + 32'd1;
                        if (!tick_idle) begin
                            if (take) begin
                                r_slot_valid[best_idx] <= r_run_valid;
                                if (r_run_valid) begin
                                    r_icnt <= r_icnt + 32'd1;
                                end else begin
                                    r_count <= r_count - CNT_W'(1);
                                end
                            end
                            r_run_valid   <= !sel_fin;
                            r_run_id      <= sel_id;
                            r_run_prio    <= sel_prio;
                            r_run_rem     <= sel_rem_dec;
                            r_run_burst   <= sel_burst;
                            r_run_arrival <= sel_arrival;
                        end
                    end
                end
                default: begin
                    r_pipe_vld <= 1'b0;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (req_xfer) begin
            r_req <= i_req.data;
        end
        if (r_state == S_SCAN) begin
            r_pipe_idx <= r_idx;
            if (!r_slot_valid[r_idx] && !r_free_found) begin
                r_free_idx <= r_idx;
            end
        end
        case (r_state)
            S_APPLY: begin
                if (!is_tick) begin
                    r_res <= '{status: admit_ok ? ST_ADMITTED : ST_REJECTED,
                               running_id: 8'd0, finished: 1'b0, finish_time: 32'd0,
                               turnaround: 32'd0, waiting: 32'd0};
                end else if (tick_idle) begin
                    r_res <= '{status: ST_IDLE, running_id: 8'd0, finished: 1'b0,
                               finish_time: 32'd0, turnaround: 32'd0, waiting: 32'd0};
                end else begin
                    r_res <= '{status: ST_RAN, running_id: sel_id, finished: sel_fin,
                               finish_time: 32'd0, turnaround: 32'd0, waiting: 32'd0};
                end
            end
            S_FIN1: begin
                r_res.finish_time <= r_time;
                r_res.turnaround  <= r_time - r_run_arrival;
            end
            S_FIN2: begin
                r_res.waiting <= r_res.turnaround - 32'(r_run_burst);
            end
            default: begin
                r_res <= r_res;
            end
        endcase
        if (out_load) begin
            r_o_data <= r_res;
        end
    end

    assign o_res.valid = r_o_vld;
    assign o_res.data  = r_o_data;

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_slot_valid) == int'(r_count))
        else $error("ready count differs from valid bits");

    a_preempt_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY && is_tick && take) |-> r_slot_valid[best_idx])
        else $error("selected slot is not valid");

    a_run_remaining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_valid |-> (r_run_rem != 16'd0))
        else $error("running task has no work left");

    a_finish_is_ran: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_data.finished) |-> (r_o_data.status == ST_RAN))
        else $error("completion reported without a run");

    a_admit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY && !is_tick && admit_ok) |-> !r_slot_valid[r_free_idx])
        else $error("admit into occupied slot");
endmodule
